// ----- src/pfbe_pkg.sv -----
package pfbe_pkg;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned ADDR_W   = 10;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [OPCODE_W-1:0] OP_STORE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_MERGE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_FILL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_HGT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic mem_rd;
      logic mem_wr;
      logic second;
      logic walk_step;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                rect_empty;
      logic                need_second;
   } status_type;

endpackage

// ----- src/pfbe_ram.sv -----
module pfbe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/pfbe_ctrl.sv -----
module pfbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pfbe_pkg::status_type status,
   output pfbe_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_MOD0,
      S_ISSUE1,
      S_MOD1,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (status.op == pfbe_pkg::OP_STORE) begin
               cmd.mem_wr = 1'b1;
               state_in   = S_DONE;
            end else if (status.op == pfbe_pkg::OP_READ) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_DONE;
            end else if (status.rect_empty) begin
               cmd.walk_step = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_MOD0;
            end
         end
         S_MOD0: begin
            cmd.mem_wr = 1'b1;
            if (status.need_second) begin
               state_in = S_ISSUE1;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_ISSUE1: begin
            cmd.mem_rd = 1'b1;
            cmd.second = 1'b1;
            state_in   = S_MOD1;
         end
         S_MOD1: begin
            cmd.mem_wr    = 1'b1;
            cmd.second    = 1'b1;
            cmd.walk_step = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/pfbe_dpath.sv -----
module pfbe_dpath #(
   parameter int unsigned FB_COLUMNS = 128,
   parameter int unsigned FB_PAGES   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pfbe_pkg::cmd_type                   cmd,
   output pfbe_pkg::status_type                status,
   input  logic [pfbe_pkg::OPCODE_W-1:0]       in_opcode,
   input  logic [pfbe_pkg::ADDR_W-1:0]         in_address,
   input  logic [pfbe_pkg::BYTE_W-1:0]         in_data,
   input  logic                                csr_we,
   input  logic [pfbe_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [7:0]                          csr_wdata,
   output logic [pfbe_pkg::BYTE_W-1:0]         out_read_data,
   output logic                                out_rect_done,
   output logic                                out_clipped
);

   localparam int unsigned FB_BYTES = FB_COLUMNS * FB_PAGES;
   localparam int unsigned AW       = $clog2(FB_BYTES);

   logic [1:0] op_ff;
   logic [9:0] addr_ff;
   logic [7:0] data_ff;

   logic [5:0] top_row_ff, top_row_in;
   logic [6:0] left_col_ff, left_col_in;
   logic [7:0] rect_width_ff, rect_width_in;
   logic [6:0] rect_height_ff, rect_height_in;
   logic       invert_ff, invert_in;
   logic [7:0] walk_col_ff, walk_col_in;
   logic [3:0] walk_page_ff, walk_page_in;
   logic       clip_ff, clip_in;
   logic       done_ff, done_in;

   logic [7:0] rsp_data_ff;
   logic       rsp_done_ff, rsp_clip_ff;

   logic       is_rect;
   logic [4:0] page_p, page_sel;
   logic [8:0] col;
   logic [8:0] row_end, last_row;
   logic [4:0] fill_n, count;
   logic       rect_empty;
   logic       oob;
   logic [2:0] off;
   logic [7:0] g;
   logic [15:0] g_sh, m_sh;
   logic [7:0] fmask, wmask, wval, mod_byte;
   logic [7:0] row;
   logic [AW-1:0] mem_addr;
   logic [7:0] mem_wdata, mem_rdata;
   logic       mem_en, mem_we;
   logic       col_wrap, page_wrap;

   assign is_rect  = (op_ff == pfbe_pkg::OP_MERGE) || (op_ff == pfbe_pkg::OP_FILL);
   assign page_p   = 5'(top_row_ff[5:3]) + 5'(walk_page_ff);
   assign page_sel = cmd.second ? page_p + 5'd1 : page_p;
   assign col      = 9'(left_col_ff) + 9'(walk_col_ff);
   assign off      = top_row_ff[2:0];

   assign row_end  = 9'(top_row_ff) + 9'(rect_height_ff);
   assign last_row = row_end - 9'd1;

   always_comb begin
      if (rect_height_ff == '0) begin
         fill_n = '0;
      end else if (5'(last_row[8:3]) - 5'(top_row_ff[5:3]) >= 5'd15) begin
         fill_n = 5'd16;
      end else begin
         fill_n = 5'(last_row[8:3]) - 5'(top_row_ff[5:3]) + 5'd1;
      end
   end

   assign count      = (op_ff == pfbe_pkg::OP_MERGE) ? 5'(rect_height_ff[6:3]) : fill_n;
   assign rect_empty = (rect_width_ff == '0) || (count == '0);

   assign status.op          = op_ff;
   assign status.rect_empty  = rect_empty;
   assign status.need_second = (op_ff == pfbe_pkg::OP_MERGE) && (off != '0);

   always_comb begin
      if (is_rect) begin
         oob = (32'(page_sel) >= FB_PAGES) || (32'(col) >= FB_COLUMNS);
      end else begin
         oob = (32'(addr_ff) >= FB_BYTES);
      end
   end

   assign g    = data_ff ^ {8{invert_ff}};
   assign g_sh = {8'h00, g} << off;
   assign m_sh = 16'h00ff << off;

   always_comb begin
      fmask = '0;
      for (int b = 0; b < 8; b++) begin
         row = {page_sel, 3'(b)};
         fmask[b] = (9'(row) >= 9'(top_row_ff)) && (9'(row) < row_end);
      end
   end

   always_comb begin
      if (op_ff == pfbe_pkg::OP_FILL) begin
         wval  = data_ff;
         wmask = fmask;
      end else if (cmd.second) begin
         wval  = g_sh[15:8];
         wmask = m_sh[15:8];
      end else begin
         wval  = g_sh[7:0];
         wmask = m_sh[7:0];
      end
   end

   assign mod_byte  = (mem_rdata & ~wmask) | (wval & wmask);
   assign mem_wdata = (op_ff == pfbe_pkg::OP_STORE) ? data_ff : mod_byte;
   assign mem_en    = (cmd.mem_rd || cmd.mem_wr) && !oob;
   assign mem_we    = cmd.mem_wr;
   assign mem_addr  = is_rect ? AW'(32'(page_sel) * FB_COLUMNS + 32'(col)) : AW'(addr_ff);

   pfbe_ram #(
      .WIDTH(8),
      .DEPTH(FB_BYTES)
   ) u_frame (
      .clock(clock),
      .en   (mem_en),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   assign col_wrap  = (9'(walk_col_ff) + 9'd1) >= 9'(rect_width_ff);
   assign page_wrap = (5'(walk_page_ff) + 5'd1) >= count;

   always_comb begin
      walk_col_in  = walk_col_ff;
      walk_page_in = walk_page_ff;
      done_in      = done_ff;
      clip_in      = clip_ff;
      if (cmd.load_item) begin
         done_in = 1'b0;
         clip_in = 1'b0;
      end
      if (cmd.mem_wr && oob) begin
         clip_in = 1'b1;
      end
      if (cmd.walk_step) begin
         if (rect_empty) begin
            walk_col_in  = '0;
            walk_page_in = '0;
            done_in      = 1'b1;
         end else if (col_wrap) begin
            walk_col_in = '0;
            if (page_wrap) begin
               walk_page_in = '0;
               done_in      = 1'b1;
            end else begin
               walk_page_in = walk_page_ff + 4'd1;
            end
         end else begin
            walk_col_in = walk_col_ff + 8'd1;
         end
      end
   end

   always_comb begin
      top_row_in     = top_row_ff;
      left_col_in    = left_col_ff;
      rect_width_in  = rect_width_ff;
      rect_height_in = rect_height_ff;
      invert_in      = invert_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pfbe_pkg::CSR_TOP_ROW:    top_row_in     = csr_wdata[5:0];
            pfbe_pkg::CSR_LEFT_COL:   left_col_in    = csr_wdata[6:0];
            pfbe_pkg::CSR_RECT_WIDTH: rect_width_in  = csr_wdata;
            pfbe_pkg::CSR_RECT_HGT:   rect_height_in = csr_wdata[6:0];
            pfbe_pkg::CSR_INVERT:     invert_in      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_row_ff     <= '0;
         left_col_ff    <= '0;
         rect_width_ff  <= 8'd1;
         rect_height_ff <= 7'd8;
         invert_ff      <= 1'b0;
         walk_col_ff    <= '0;
         walk_page_ff   <= '0;
         clip_ff        <= 1'b0;
         done_ff        <= 1'b0;
      end else begin
         top_row_ff     <= top_row_in;
         left_col_ff    <= left_col_in;
         rect_width_ff  <= rect_width_in;
         rect_height_ff <= rect_height_in;
         invert_ff      <= invert_in;
         walk_col_ff    <= walk_col_in;
         walk_page_ff   <= walk_page_in;
         clip_ff        <= clip_in;
         done_ff        <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= in_opcode;
         addr_ff <= in_address;
         data_ff <= in_data;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= ((op_ff == pfbe_pkg::OP_READ) && !oob) ? mem_rdata : 8'h00;
         rsp_done_ff <= done_ff;
         rsp_clip_ff <= clip_ff;
      end
   end

   assign out_read_data = rsp_data_ff;
   assign out_rect_done = rsp_done_ff;
   assign out_clipped   = rsp_clip_ff;

endmodule

// ----- src/page_framebuffer_blit_engine_unit.sv -----
// Monochrome page framebuffer with store, read, merge and fill requests.
// One request is handled at a time on a single-port frame memory: store and read
// address one byte, a merge or fill of an empty rectangle touches no byte, any
// other fill and an aligned merge read and rewrite one byte, and a merge at a
// nonzero row offset reads and rewrites two bytes in adjacent pages through
// the one memory port. A finished result waits in an output register; the
// next request is accepted while it waits.
// Frame bytes power up undefined and must be written before they are read.
module page_framebuffer_blit_engine_unit #(
   parameter int unsigned FB_COLUMNS = 128,
   parameter int unsigned FB_PAGES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[9:0], data[17:10], zero pad
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], rect_done[8], clipped[9], zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   pfbe_pkg::cmd_type    cmd;
   pfbe_pkg::status_type status;
   logic [7:0]           read_data;
   logic                 rect_done;
   logic                 clipped;

   pfbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   pfbe_dpath #(
      .FB_COLUMNS(FB_COLUMNS),
      .FB_PAGES  (FB_PAGES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_opcode    (req_tuser),
      .in_address   (req_tdata[9:0]),
      .in_data      (req_tdata[17:10]),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .out_read_data(read_data),
      .out_rect_done(rect_done),
      .out_clipped  (clipped)
   );

   assign rsp_tdata = {6'b0, clipped, rect_done, read_data};

endmodule
